FILE: rtl/b64e_pkg.sv
package b64e_pkg;

  localparam logic [6:0] PAD_CHAR = 7'h3D;

  // '=' count for a group: none, one or two
  localparam logic [1:0] PAD_NONE = 2'd0;
  localparam logic [1:0] PAD_ONE  = 2'd1;
  localparam logic [1:0] PAD_TWO  = 2'd2;

  // Index of the last of the four character slots in a group
  localparam logic [1:0] LAST_SLOT = 2'd3;

  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  pad;
    logic        last;
  } group_t;

  // Standard base64 alphabet
  function automatic logic [6:0] b64_char(input logic [5:0] idx);
    logic [6:0] ch;
    if (idx < 6'd26) begin
      ch = 7'h41 + {1'b0, idx};
    end else if (idx < 6'd52) begin
      ch = 7'h61 + {1'b0, idx} - 7'd26;
    end else if (idx < 6'd62) begin
      ch = 7'h30 + {1'b0, idx} - 7'd52;
    end else if (idx == 6'd62) begin
      ch = 7'h2B;
    end else begin
      ch = 7'h2F;
    end
    return ch;
  endfunction

endpackage

FILE: rtl/b64e_front.sv
module b64e_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        data_byte,
  input  logic              end_of_message,
  output logic              grp_valid,
  output b64e_pkg::group_t  grp
);

  logic [1:0]  phase;
  logic [15:0] pending;
  logic [1:0]  phase_next;
  logic [15:0] pending_next;

  always_comb begin
    phase_next   = phase;
    pending_next = pending;
    grp_valid    = 1'b0;
    grp.triple   = {pending, data_byte};
    grp.pad      = b64e_pkg::PAD_NONE;
    grp.last     = end_of_message;
    case (phase)
      2'd1: begin
        if (end_of_message) begin
          grp_valid  = 1'b1;
          grp.triple = {pending[15:8], data_byte, 8'h00};
          grp.pad    = b64e_pkg::PAD_ONE;
          phase_next = 2'd0;
        end else begin
          pending_next = {pending[15:8], data_byte};
          phase_next   = 2'd2;
        end
      end
      2'd2: begin
        grp_valid  = 1'b1;
        phase_next = 2'd0;
      end
      default: begin
        // phase 0 (and the unreachable phase 3)
        if (end_of_message) begin
          grp_valid  = 1'b1;
          grp.triple = {data_byte, 16'h0000};
          grp.pad    = b64e_pkg::PAD_TWO;
          phase_next = 2'd0;
        end else begin
          pending_next = {data_byte, 8'h00};
          phase_next   = 2'd1;
        end
      end
    endcase
    if (!in_valid) begin
      grp_valid    = 1'b0;
      phase_next   = phase;
      pending_next = pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= 2'd0;
      pending <= 16'h0000;
    end else begin
      phase   <= phase_next;
      pending <= pending_next;
    end
  end

endmodule

FILE: rtl/b64e_fifo.sv
module b64e_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  b64e_pkg::group_t  wr_data,
  input  logic              rd_en,
  output b64e_pkg::group_t  rd_data,
  output logic              full,
  output logic              empty
);

  b64e_pkg::group_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/b64e_back.sv
module b64e_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  b64e_pkg::group_t  q_data,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [6:0]        code_char,
  output logic              last_char
);

  b64e_pkg::group_t grp;
  logic       busy;
  logic [1:0] slot;
  logic [5:0] slice;
  logic [2:0] pad_edge;
  logic       done;

  assign empty = !busy;
  assign done  = pop && busy && (slot == b64e_pkg::LAST_SLOT);
  assign q_pop = !q_empty && (!busy || done);

  always_comb begin
    case (slot)
      2'd0:    slice = grp.triple[23:18];
      2'd1:    slice = grp.triple[17:12];
      2'd2:    slice = grp.triple[11:6];
      default: slice = grp.triple[5:0];
    endcase
  end

  // slot falls in the padding when slot + pad reaches four
  assign pad_edge  = {1'b0, slot} + {1'b0, grp.pad};
  assign code_char = pad_edge[2] ? b64e_pkg::PAD_CHAR : b64e_pkg::b64_char(slice);
  assign last_char = grp.last && (slot == b64e_pkg::LAST_SLOT);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      grp <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= 2'd0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        slot <= 2'd0;
      end else if (done) begin
        busy <= 1'b0;
        slot <= 2'd0;
      end else if (pop && busy) begin
        slot <= slot + 2'd1;
      end
    end
  end

endmodule

FILE: rtl/base64_stream_encoder.sv
// A byte that closes a group puts its first character on the result ports once
//   the serializer loads the group; the three others follow as they are popped.
// Throughput: four characters per group at one character per cycle while pop is
//   held and a group is ready, so the serializer sets the sustained byte rate.
// Reset (rst, synchronous, active high) drops any held bytes and empties the
//   two-group queue and the output serializer.
module base64_stream_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] code_char,
  output logic       last_char
);

  logic              in_take;
  logic              grp_valid;
  b64e_pkg::group_t  grp;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  b64e_pkg::group_t  q_data;

  // Front end gathers bytes into groups; it stalls only while the queue is
  // full, so bytes keep flowing while the back end drains characters.
  assign full    = q_full;
  assign in_take = push && !q_full;

  b64e_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_take),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .grp_valid      (grp_valid),
    .grp            (grp)
  );

  // Two-group queue between gathering and serializing
  b64e_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (grp_valid),
    .wr_data (grp),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back end walks the four character slots of the held group; the next
  // group, if one is queued, loads on the same edge that pops the fourth character.
  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .code_char (code_char),
    .last_char (last_char)
  );

endmodule

FILE: sim/b64_stream_checker.sv
module b64_stream_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  input  logic       empty,
  input  logic       pop,
  input  logic [6:0] code_char,
  input  logic       last_char,
  output int         mismatches,
  output int         outstanding,
  output int         chars_checked
);

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } b64_out_t;

  b64_out_t    expected_chars[$];
  logic [15:0] held_bytes;
  logic [1:0]  held_count;
  int          err_total;
  int          ok_total;

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    chars_checked = 0;
    err_total     = 0;
    ok_total      = 0;
    held_bytes    = '0;
    held_count    = '0;
  end

  function automatic logic [6:0] sextet_char(input logic [5:0] idx);
    return ALPHABET[8*(63-idx) +: 7];
  endfunction

  task automatic expect_char(input logic [6:0] ch, input logic last);
    expected_chars.push_back('{ch: ch, last: last});
  endtask

  // Same group rules as the encoder: hold bytes until a group closes or the
  // message ends, then queue four characters.
  task automatic encode_byte(input logic [7:0] b, input logic eom);
    logic [23:0] bits24;
    if (held_count == 2'd2) begin
      bits24 = {held_bytes, b};
      expect_char(sextet_char(bits24[23:18]), 1'b0);
      expect_char(sextet_char(bits24[17:12]), 1'b0);
      expect_char(sextet_char(bits24[11:6]), 1'b0);
      expect_char(sextet_char(bits24[5:0]), eom);
      held_count = 2'd0;
      held_bytes = '0;
    end else if (held_count == 2'd1) begin
      if (!eom) begin
        held_bytes[7:0] = b;
        held_count      = 2'd2;
      end else begin
        bits24 = {held_bytes[15:8], b, 8'h00};
        expect_char(sextet_char(bits24[23:18]), 1'b0);
        expect_char(sextet_char(bits24[17:12]), 1'b0);
        expect_char(sextet_char(bits24[11:6]), 1'b0);
        expect_char(b64e_pkg::PAD_CHAR, 1'b1);
        held_count = 2'd0;
        held_bytes = '0;
      end
    end else begin
      // an unreachable count of three falls here as well
      if (!eom) begin
        held_bytes = {b, 8'h00};
        held_count = 2'd1;
      end else begin
        bits24 = {b, 16'h0000};
        expect_char(sextet_char(bits24[23:18]), 1'b0);
        expect_char(sextet_char(bits24[17:12]), 1'b0);
        expect_char(b64e_pkg::PAD_CHAR, 1'b0);
        expect_char(b64e_pkg::PAD_CHAR, 1'b1);
        held_count = 2'd0;
        held_bytes = '0;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    b64_out_t want;
    if (rst) begin
      held_bytes = '0;
      held_count = '0;
      expected_chars.delete();
    end else begin
      // a character can never come from the byte taken at the same edge
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected char: expected none, actual %h last=%b",
                   $time, code_char, last_char);
          err_total++;
        end else begin
          want = expected_chars.pop_front();
          if (code_char !== want.ch) begin
            $display("%0t: code_char expected %h (%c) actual %h", $time,
                     want.ch, {1'b0, want.ch}, code_char);
            err_total++;
          end
          if (last_char !== want.last) begin
            $display("%0t: last_char expected %b actual %b", $time,
                     want.last, last_char);
            err_total++;
          end
          ok_total++;
        end
      end
      if (push && !full) encode_byte(data_byte, end_of_message);
    end
    mismatches    <= err_total;
    outstanding   <= expected_chars.size();
    chars_checked <= ok_total;
  end

endmodule

FILE: sim/tb.sv
// Top of the encoder bench: clock, reset, byte stimulus, character sink
// with random stalls, and the verdict. All checking lives in the checker.
module tb;

  // Worst case is far below this: ~300 bytes, each after a random idle
  // gap, closing groups of four chars each stalled for a random stretch.
  localparam int CYCLE_LIMIT = 200000;
  // Settle time after the last expected char, well past the encoder latency.
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_BYTES = 270;

  logic       clk;
  logic       rst;
  logic       push;
  logic [7:0] data_byte;
  logic       end_of_message;
  logic       pop;
  logic       full;
  logic       empty;
  logic [6:0] code_char;
  logic       last_char;

  int mismatches;
  int outstanding;
  int chars_checked;

  // Stimulus bookkeeping for the summary only.
  int bytes_sent;
  int msgs_sent;
  int msg_len;
  int tail_seen[3];
  int cycle_count;

  // When set, that side runs back to back with no idle cycles.
  bit tx_calm;
  bit rx_calm;

  base64_stream_encoder dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .empty          (empty),
    .pop            (pop),
    .code_char      (code_char),
    .last_char      (last_char)
  );

  b64_stream_checker chk (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .empty          (empty),
    .pop            (pop),
    .code_char      (code_char),
    .last_char      (last_char),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .chars_checked  (chars_checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("base64_stream_encoder regression: fail");
      $finish;
    end
  end

  // Offer one byte after a random idle stretch and hold it until taken.
  // push stays high across back-to-back bytes; it only drops for a gap.
  task automatic send_byte(input logic [7:0] b, input logic eom);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push           <= 1'b1;
    data_byte      <= b;
    end_of_message <= eom;
    // full is sampled as the encoder saw it at this edge
    do @(posedge clk); while (full);
    bytes_sent++;
    msg_len++;
    if (eom) begin
      tail_seen[msg_len % 3]++;
      msgs_sent++;
      msg_len = 0;
    end
  endtask

  // Stop offering bytes until every predicted char has been popped.
  // outstanding is registered, so the loop always steps the clock before it looks.
  task automatic drain_chars();
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Random message body; zero and all-ones bytes are favored a little so
  // the first and last alphabet entries come up often.
  task automatic send_message(input int len);
    logic [7:0] b;
    int         sel;
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 7);
      if (sel == 0) b = 8'h00;
      else if (sel == 1) b = 8'hFF;
      else b = 8'($urandom_range(0, 255));
      send_byte(b, i == len - 1);
    end
  endtask

  // Character sink: random stall before each pop, with calm stretches.
  initial begin : sink
    int gap;
    int pops;
    pop  <= 1'b0;
    pops = 0;
    rx_calm = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (pops % 25 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      gap = rx_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      pops++;
    end
  end

  initial begin : stimulus
    int len;
    int sel;
    rst            <= 1'b1;
    push           <= 1'b0;
    data_byte      <= 8'h00;
    end_of_message <= 1'b0;
    bytes_sent = 0;
    msgs_sent  = 0;
    msg_len    = 0;
    tail_seen  = '{0, 0, 0};
    tx_calm    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: one-byte messages (two '=' pads) at both byte extremes.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Two-byte messages (one '=' pad).
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // Full groups that end the message: last flag on the fourth char.
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Full group without end, then a one-byte tail in the same message.
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h61, 1'b1);
    // Every sextet is 62: four '+' characters.
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    // Alternating bit patterns, two-byte tail.
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);

    // Idle input until the encoder has emptied out.
    drain_chars();

    // Random messages, mostly short, a few long ones.
    while (bytes_sent < RANDOM_BYTES) begin
      if (msgs_sent % 8 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 19);
      if (sel < 16) len = $urandom_range(1, 9);
      else if (sel < 19) len = $urandom_range(10, 24);
      else len = $urandom_range(25, 48);
      send_message(len);
      // a second full drain partway through the random part
      if (msgs_sent == 30) drain_chars();
    end

    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d bytes in %0d messages (tails of 3/1/2 bytes: %0d/%0d/%0d)",
             bytes_sent, msgs_sent, tail_seen[0], tail_seen[1], tail_seen[2]);
    $display("checked %0d characters, %0d mismatches", chars_checked, mismatches);
    if (mismatches == 0) begin
      $display("base64_stream_encoder regression: pass");
    end else begin
      $display("base64_stream_encoder regression: fail");
    end
    $finish;
  end

endmodule
